[hdl/llgr_pkg.sv]
// Shared types and constants for the linked-list group reverser.
// No dependencies; used by linked_list_group_reverser and its testbench.
package llgr_pkg;

  // Default sizing
  localparam int unsigned MaxNodesDefault = 64;
  localparam int unsigned AddrBitsDefault = 17;

  // Configuration register widths and reset values
  localparam int unsigned CfgDataW   = 18;
  localparam int unsigned StartW     = 18;
  localparam int unsigned GroupW     = 7;
  localparam logic [StartW-1:0] StartReset = '1;  // -1, empty chain
  localparam logic [GroupW-1:0] GroupReset = 7'd1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_START_ADDR = 1'b0,
    CFG_GROUP_SIZE = 1'b1
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK_INIT,
    ST_SEARCH,
    ST_EMIT_ORD,
    ST_EMIT_NODE,
    ST_EMIT_TAKE,
    ST_SEND,
    ST_LAST,
    ST_SEND_LAST
  } state_e;

endpackage

[hdl/llgr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; instantiated by linked_list_group_reverser.
module llgr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/linked_list_group_reverser.sv]
// Nodes are loaded one word per cycle (in_ready_o high while idle). The word
// marked load_done starts the computation and the block drops in_ready_o until
// the last result word is taken, or until the walk ends when it finds no chain.
// The chain walk scans the node table one entry per cycle through its single
// read port, restarting the scan for each link. Emission then steps through
// order read, node read, capture and output handshake for each node, and the
// handshake waits on out_ready_i. No clearing pass is needed after reset.
// Depends on llgr_pkg and llgr_ram.
module linked_list_group_reverser #(
  parameter int unsigned MAX_NODES = llgr_pkg::MaxNodesDefault,
  parameter int unsigned ADDR_BITS = llgr_pkg::AddrBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  llgr_pkg::cfg_idx_e            cfg_index_i,
  input  logic [llgr_pkg::CfgDataW-1:0] cfg_data_i,
  // node input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ADDR_BITS-1:0]          node_address_i,
  input  logic signed [31:0]            node_value_i,
  input  logic signed [ADDR_BITS:0]     successor_address_i,
  input  logic                          load_done_i,
  // node output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ADDR_BITS-1:0]          out_address_o,
  output logic signed [31:0]            out_value_o,
  output logic signed [ADDR_BITS:0]     out_successor_o,
  output logic                          out_final_o
);

  localparam int unsigned IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned GW = llgr_pkg::GroupW;
  localparam int unsigned SW = ((CW > GW) ? CW : GW) + 1;
  localparam int unsigned NW = 2 * ADDR_BITS + 33;

  // Configuration registers
  logic [llgr_pkg::StartW-1:0] start_q;
  logic [GW-1:0]               group_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= llgr_pkg::StartReset;
      group_q <= llgr_pkg::GroupReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        llgr_pkg::CFG_START_ADDR: start_q <= cfg_data_i[llgr_pkg::StartW-1:0];
        llgr_pkg::CFG_GROUP_SIZE: group_q <= cfg_data_i[GW-1:0];
        default: ;
      endcase
    end
  end

  // Control and datapath registers
  llgr_pkg::state_e state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        len_q, len_d;
  logic [CW-1:0]        scan_q, scan_d;
  logic                 cmp_v_q, cmp_v_d;
  logic [IW-1:0]        cmp_idx_q, cmp_idx_d;
  logic [MAX_NODES-1:0] seen_q, seen_d;
  logic [ADDR_BITS-1:0] ptr_q, ptr_d;
  logic [SW-1:0]        base_q, base_d;
  logic [SW-1:0]        off_q, off_d;
  logic [CW-1:0]        emit_q, emit_d;
  logic                 cur_v_q, cur_v_d;
  logic [ADDR_BITS-1:0] cur_addr_q, cur_addr_d;
  logic [31:0]          cur_val_q, cur_val_d;
  logic [ADDR_BITS-1:0] oaddr_q, oaddr_d;
  logic [31:0]          oval_q, oval_d;
  logic [ADDR_BITS:0]   osucc_q, osucc_d;
  logic                 ofinal_q, ofinal_d;

  // Memory ports
  logic          node_we;
  logic [IW-1:0] node_raddr;
  logic [NW-1:0] node_wdata, node_rdata;
  logic          ord_we;
  logic [IW-1:0] ord_raddr;
  logic [IW-1:0] ord_rdata;

  llgr_ram #(.Width(NW), .Depth(MAX_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  llgr_ram #(.Width(IW), .Depth(MAX_NODES)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (len_q[IW-1:0]),
    .wdata_i (cmp_idx_q),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  // Table entry fields
  logic [ADDR_BITS-1:0] tbl_addr;
  logic [31:0]          tbl_val;
  logic [ADDR_BITS:0]   tbl_succ;

  assign tbl_addr   = node_rdata[NW-1 -: ADDR_BITS];
  assign tbl_val    = node_rdata[ADDR_BITS+1 +: 32];
  assign tbl_succ   = node_rdata[ADDR_BITS:0];
  assign node_wdata = {node_address_i, node_value_i, successor_address_i};

  // Start pointer: the low 17 bits of the start register, fitted to ADDR_BITS
  logic [ADDR_BITS+16:0] start_ext;
  logic                  start_neg;

  assign start_ext = {{ADDR_BITS{1'b0}}, start_q[16:0]};
  assign start_neg = start_q[llgr_pkg::StartW-1];

  // Handshakes
  logic in_acc, load_wr, out_acc;

  assign in_ready_o  = (state_q == llgr_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign load_wr     = in_acc && (count_q < CW'(MAX_NODES));
  assign out_valid_o = (state_q == llgr_pkg::ST_SEND) || (state_q == llgr_pkg::ST_SEND_LAST);
  assign out_acc     = out_valid_o && out_ready_i;

  // Search step: compare the entry read last cycle against the pointer
  logic          hit, append, walk_end;
  logic [CW-1:0] len_inc, walk_len;

  assign len_inc = len_q + CW'(1);

  always_comb begin
    hit      = cmp_v_q && (tbl_addr == ptr_q);
    append   = 1'b0;
    walk_end = 1'b0;
    if (state_q == llgr_pkg::ST_SEARCH) begin
      if (hit) begin
        if (seen_q[cmp_idx_q]) begin
          walk_end = 1'b1;
        end else begin
          append   = 1'b1;
          walk_end = tbl_succ[ADDR_BITS] || (len_inc == CW'(MAX_NODES));
        end
      end else if (scan_q >= count_q) begin
        walk_end = 1'b1;
      end
    end
    walk_len = append ? len_inc : len_q;
  end

  // Emit order: full groups reversed, tail in order
  logic          rev, full_grp, grp_last;
  logic [SW-1:0] grp_end, pos;

  always_comb begin
    grp_end  = base_q + SW'(group_q);
    rev      = (group_q != '0) && (SW'(group_q) <= SW'(len_q));
    full_grp = rev && (grp_end <= SW'(len_q));
    grp_last = full_grp && (off_q == SW'(group_q) - SW'(1));
    pos      = full_grp ? (grp_end - SW'(1) - off_q) : (base_q + off_q);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      llgr_pkg::ST_IDLE: begin
        if (in_acc && load_done_i) state_d = llgr_pkg::ST_WALK_INIT;
      end
      llgr_pkg::ST_WALK_INIT: begin
        state_d = start_neg ? llgr_pkg::ST_IDLE : llgr_pkg::ST_SEARCH;
      end
      llgr_pkg::ST_SEARCH: begin
        if (walk_end) begin
          state_d = (walk_len == '0) ? llgr_pkg::ST_IDLE : llgr_pkg::ST_EMIT_ORD;
        end
      end
      llgr_pkg::ST_EMIT_ORD:  state_d = llgr_pkg::ST_EMIT_NODE;
      llgr_pkg::ST_EMIT_NODE: state_d = llgr_pkg::ST_EMIT_TAKE;
      llgr_pkg::ST_EMIT_TAKE: begin
        if (cur_v_q)                 state_d = llgr_pkg::ST_SEND;
        else if (emit_q == len_q)    state_d = llgr_pkg::ST_LAST;
        else                         state_d = llgr_pkg::ST_EMIT_ORD;
      end
      llgr_pkg::ST_SEND: begin
        if (out_acc) begin
          state_d = (emit_q == len_q) ? llgr_pkg::ST_LAST : llgr_pkg::ST_EMIT_ORD;
        end
      end
      llgr_pkg::ST_LAST:      state_d = llgr_pkg::ST_SEND_LAST;
      llgr_pkg::ST_SEND_LAST: begin
        if (out_acc) state_d = llgr_pkg::ST_IDLE;
      end
      default: state_d = llgr_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    count_d    = count_q;
    len_d      = len_q;
    scan_d     = scan_q;
    cmp_v_d    = cmp_v_q;
    cmp_idx_d  = cmp_idx_q;
    seen_d     = seen_q;
    ptr_d      = ptr_q;
    base_d     = base_q;
    off_d      = off_q;
    emit_d     = emit_q;
    cur_v_d    = cur_v_q;
    cur_addr_d = cur_addr_q;
    cur_val_d  = cur_val_q;
    oaddr_d    = oaddr_q;
    oval_d     = oval_q;
    osucc_d    = osucc_q;
    ofinal_d   = ofinal_q;
    node_we    = 1'b0;
    node_raddr = scan_q[IW-1:0];
    ord_we     = 1'b0;
    ord_raddr  = pos[IW-1:0];

    unique case (state_q)
      llgr_pkg::ST_IDLE: begin
        node_we = load_wr;
        if (load_wr) count_d = count_q + CW'(1);
      end
      llgr_pkg::ST_WALK_INIT: begin
        len_d   = '0;
        scan_d  = '0;
        cmp_v_d = 1'b0;
        seen_d  = '0;
        ptr_d   = start_ext[ADDR_BITS-1:0];
      end
      llgr_pkg::ST_SEARCH: begin
        if (hit) begin
          // found or revisited: restart the scan for the next link
          scan_d  = '0;
          cmp_v_d = 1'b0;
          if (append) begin
            ord_we            = 1'b1;
            len_d             = len_inc;
            seen_d[cmp_idx_q] = 1'b1;
            ptr_d             = tbl_succ[ADDR_BITS-1:0];
          end
        end else if (scan_q < count_q) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = scan_q[IW-1:0];
          scan_d    = scan_q + CW'(1);
        end
        if (walk_end) begin
          base_d  = '0;
          off_d   = '0;
          emit_d  = '0;
          cur_v_d = 1'b0;
        end
      end
      llgr_pkg::ST_EMIT_ORD: begin
        emit_d = emit_q + CW'(1);
        if (grp_last) begin
          base_d = grp_end;
          off_d  = '0;
        end else begin
          off_d = off_q + SW'(1);
        end
      end
      llgr_pkg::ST_EMIT_NODE: begin
        node_raddr = ord_rdata;
      end
      llgr_pkg::ST_EMIT_TAKE: begin
        // the new node supplies the successor of the one held back
        if (cur_v_q) begin
          oaddr_d  = cur_addr_q;
          oval_d   = cur_val_q;
          osucc_d  = {1'b0, tbl_addr};
          ofinal_d = 1'b0;
        end
        cur_v_d    = 1'b1;
        cur_addr_d = tbl_addr;
        cur_val_d  = tbl_val;
      end
      llgr_pkg::ST_SEND: ;
      llgr_pkg::ST_LAST: begin
        oaddr_d  = cur_addr_q;
        oval_d   = cur_val_q;
        osucc_d  = '1;
        ofinal_d = 1'b1;
      end
      llgr_pkg::ST_SEND_LAST: ;
      default: ;
    endcase

    // a finished run starts a fresh load
    if ((state_q != llgr_pkg::ST_IDLE) && (state_d == llgr_pkg::ST_IDLE)) count_d = '0;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= llgr_pkg::ST_IDLE;
      count_q <= '0;
      len_q   <= '0;
      scan_q  <= '0;
      cmp_v_q <= 1'b0;
      seen_q  <= '0;
      base_q  <= '0;
      off_q   <= '0;
      emit_q  <= '0;
      cur_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      len_q   <= len_d;
      scan_q  <= scan_d;
      cmp_v_q <= cmp_v_d;
      seen_q  <= seen_d;
      base_q  <= base_d;
      off_q   <= off_d;
      emit_q  <= emit_d;
      cur_v_q <= cur_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    ptr_q      <= ptr_d;
    cur_addr_q <= cur_addr_d;
    cur_val_q  <= cur_val_d;
    oaddr_q    <= oaddr_d;
    oval_q     <= oval_d;
    osucc_q    <= osucc_d;
    ofinal_q   <= ofinal_d;
  end

  assign out_address_o   = oaddr_q;
  assign out_value_o     = oval_q;
  assign out_successor_o = osucc_q;
  assign out_final_o     = ofinal_q;

  // Checks
  a_no_load_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result word is pending");

  a_final_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_final_o == (state_q == llgr_pkg::ST_SEND_LAST)))
    else $error("final flag does not match the last word");

  a_order_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ord_we |-> (len_q < CW'(MAX_NODES)))
    else $error("chain order written past its depth");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_NODES))
    else $error("load count past table depth");

  a_done_resets_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == llgr_pkg::ST_SEND_LAST && out_ready_i) |=>
      (state_q == llgr_pkg::ST_IDLE && count_q == '0))
    else $error("run did not return to an empty load");

endmodule

[tb/sv/reverser_check.sv]
// Watches the node input, config writes and node output of the group reverser,
// predicts the emitted chain and compares each output word in order.
// Depends on llgr_pkg.
module reverser_check
  import llgr_pkg::*;
#(
  parameter int unsigned MAX_NODES = MaxNodesDefault,
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  cfg_idx_e                    cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [ADDR_BITS-1:0]        node_address_i,
  input  logic signed [31:0]          node_value_i,
  input  logic signed [ADDR_BITS:0]   successor_address_i,
  input  logic                        load_done_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [ADDR_BITS-1:0]        out_address_i,
  input  logic signed [31:0]          out_value_i,
  input  logic signed [ADDR_BITS:0]   out_successor_i,
  input  logic                        out_final_i,
  output int                          errors_o,
  output int                          pending_o
);

  localparam int Depth = int'(MAX_NODES);

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [31:0]          value;
    logic [ADDR_BITS:0]   succ;
    logic                 fin;
  } node_word_t;

  // loaded node table and our copy of the registers
  logic [ADDR_BITS-1:0] tbl_addr [Depth];
  logic [31:0]          tbl_val  [Depth];
  logic [ADDR_BITS:0]   tbl_succ [Depth];
  int                   fill_cnt;
  int                   walk_order [Depth];
  int                   walk_len;
  logic [StartW-1:0]    start_q;
  logic [GroupW-1:0]    group_q;

  node_word_t           chain_words_q [$];
  int                   err_cnt;

  assign errors_o = err_cnt;

  task automatic report_fail(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    $display("reverser_check: %s mismatch, got %0h, want %0h", what, got, want);
    err_cnt++;
  endtask

  // earliest loaded node with this address, -1 if none
  function automatic int find_node(input logic [ADDR_BITS-1:0] a);
    for (int i = 0; i < fill_cnt; i++)
      if (tbl_addr[i] == a) return i;
    return -1;
  endfunction

  // walk from the start register, reverse full groups, queue the output words
  task automatic reorder_chain();
    bit                   seen [Depth];
    logic [ADDR_BITS-1:0] look;
    logic                 live;
    int                   idx;
    int                   k;
    int                   tmp;
    node_word_t           w;
    foreach (seen[i]) seen[i] = 1'b0;
    live     = !start_q[StartW-1];
    look     = start_q[ADDR_BITS-1:0];
    walk_len = 0;
    while (live && walk_len < Depth) begin
      idx = find_node(look);
      if (idx < 0 || seen[idx]) break;
      seen[idx]            = 1'b1;
      walk_order[walk_len] = idx;
      walk_len++;
      live = !tbl_succ[idx][ADDR_BITS];
      look = tbl_succ[idx][ADDR_BITS-1:0];
    end
    k = int'(group_q);
    if (k != 0 && k <= walk_len) begin
      for (int g = 0; g + k <= walk_len; g += k) begin
        for (int j = 0; j < k / 2; j++) begin
          tmp                       = walk_order[g + j];
          walk_order[g + j]         = walk_order[g + k - 1 - j];
          walk_order[g + k - 1 - j] = tmp;
        end
      end
    end
    for (int i = 0; i < walk_len; i++) begin
      w.addr  = tbl_addr[walk_order[i]];
      w.value = tbl_val[walk_order[i]];
      w.fin   = (i == walk_len - 1);
      if (w.fin) w.succ = '1;
      else w.succ = {1'b0, tbl_addr[walk_order[i + 1]]};
      chain_words_q.push_back(w);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    node_word_t got;
    node_word_t want;
    if (!rst_ni) begin
      start_q  = StartReset;
      group_q  = GroupReset;
      fill_cnt = 0;
      walk_len = 0;
      err_cnt  = 0;
      chain_words_q.delete();
      pending_o <= 0;
    end else begin
      // output word against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        got = '{out_address_i, out_value_i, out_successor_i, out_final_i};
        if (chain_words_q.size() == 0) begin
          report_fail("unexpected word, address", 64'(got.addr), 64'd0);
        end else begin
          want = chain_words_q.pop_front();
          if (got.addr !== want.addr)
            report_fail("out_address", 64'(got.addr), 64'(want.addr));
          if (got.value !== want.value)
            report_fail("out_value", 64'(got.value), 64'(want.value));
          if (got.succ !== want.succ)
            report_fail("out_successor", 64'(got.succ), 64'(want.succ));
          if (got.fin !== want.fin)
            report_fail("out_final", 64'(got.fin), 64'(want.fin));
        end
      end
      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_START_ADDR: start_q = cfg_data_i[StartW-1:0];
          CFG_GROUP_SIZE: group_q = cfg_data_i[GroupW-1:0];
          default: ;
        endcase
      end
      // node load; a full table drops the word but load_done still counts
      if (in_valid_i && in_ready_i) begin
        if (fill_cnt < Depth) begin
          tbl_addr[fill_cnt] = node_address_i;
          tbl_val[fill_cnt]  = node_value_i;
          tbl_succ[fill_cnt] = successor_address_i;
          fill_cnt++;
        end
        if (load_done_i) begin
          reorder_chain();
          fill_cnt = 0;
        end
      end
      pending_o <= chain_words_q.size();
    end
  end

endmodule

[tb/sv/tb.sv]
// Top of the group reverser testbench: clock, reset, node stimulus, output
// back-pressure and the verdict. Depends on llgr_pkg, the reverser and reverser_check.
module tb;
  import llgr_pkg::*;

  localparam int unsigned AddrBits    = AddrBitsDefault;
  localparam int          ItemTarget  = 410;
  localparam int          LimitCycles = 3_000_000;
  // an empty-chain walk scans the table once
  localparam int          QuietCycles = 150;
  localparam int          HoldCycles  = 600;

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [AddrBits:0]   link_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  cfg_idx_e             cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  addr_t                node_address_i;
  logic signed [31:0]   node_value_i;
  logic signed [AddrBits:0] successor_address_i;
  logic                 load_done_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  addr_t                out_address_o;
  logic signed [31:0]   out_value_o;
  logic signed [AddrBits:0] out_successor_o;
  logic                 out_final_o;

  int                   err_total;
  int                   words_due;
  int                   sent_cnt;
  int                   hold_asks;
  logic                 idle_en;
  logic [StartW-1:0]    start_cur;
  int unsigned          cycle_cnt;

  // node list of the load being built
  addr_t                ld_addr [$];
  logic [31:0]          ld_val  [$];
  link_t                ld_succ [$];

  linked_list_group_reverser dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .node_address_i     (node_address_i),
    .node_value_i       (node_value_i),
    .successor_address_i(successor_address_i),
    .load_done_i        (load_done_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_address_o      (out_address_o),
    .out_value_o        (out_value_o),
    .out_successor_o    (out_successor_o),
    .out_final_o        (out_final_o)
  );

  reverser_check u_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .node_address_i     (node_address_i),
    .node_value_i       (node_value_i),
    .successor_address_i(successor_address_i),
    .load_done_i        (load_done_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_address_i      (out_address_o),
    .out_value_i        (out_value_o),
    .out_successor_i    (out_successor_o),
    .out_final_i        (out_final_o),
    .errors_o           (err_total),
    .pending_o          (words_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("tb: errors");
      $finish;
    end
  end

  // output side: short random stalls, plus one long hold-off on request
  initial begin : sink
    int holds_done;
    holds_done  = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_done) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic bit addr_taken(input addr_t a);
    foreach (ld_addr[i])
      if (ld_addr[i] == a) return 1'b1;
    return 1'b0;
  endfunction

  function automatic addr_t fresh_addr();
    addr_t a;
    do a = addr_t'($urandom_range(0, 2 ** AddrBits - 1)); while (addr_taken(a));
    return a;
  endfunction

  task automatic add_node(input addr_t a, input logic [31:0] v, input link_t s);
    ld_addr.push_back(a);
    ld_val.push_back(v);
    ld_succ.push_back(s);
  endtask

  // well-formed chain in link order; the tail ends, dangles, or loops back
  task automatic build_chain(input int n, input bit keep_head);
    addr_t a;
    int    r;
    for (int i = 0; i < n; i++) begin
      if (i == 0 && keep_head) a = start_cur[AddrBits-1:0];
      else a = fresh_addr();
      add_node(a, $urandom, '1);
    end
    for (int i = 0; i + 1 < n; i++) ld_succ[i] = {1'b0, ld_addr[i + 1]};
    r = $urandom_range(0, 9);
    if (r == 7) ld_succ[n - 1] = {1'b1, addr_t'($urandom)};
    else if (r == 8) ld_succ[n - 1] = {1'b0, fresh_addr()};
    else if (r == 9) ld_succ[n - 1] = {1'b0, ld_addr[$urandom_range(0, n - 1)]};
  endtask

  // duplicate addresses and unreachable nodes pointing into the chain
  task automatic add_extras(input int cnt);
    addr_t a;
    link_t s;
    for (int i = 0; i < cnt; i++) begin
      s = {1'b0, ld_addr[$urandom_range(0, ld_addr.size() - 1)]};
      if ($urandom_range(0, 1)) a = ld_addr[$urandom_range(0, ld_addr.size() - 1)];
      else a = fresh_addr();
      add_node(a, $urandom, s);
    end
  endtask

  // random nodes; a narrow address space gives duplicates and loops
  task automatic build_noise(input int n, input bit wide);
    addr_t a;
    link_t s;
    int    r;
    for (int i = 0; i < n; i++) begin
      a = wide ? addr_t'($urandom) : addr_t'($urandom_range(0, 15));
      r = $urandom_range(0, 9);
      if (r < 7) s = wide ? {1'b0, addr_t'($urandom)} : link_t'($urandom_range(0, 15));
      else if (r < 8) s = '1;
      else s = link_t'($urandom);
      add_node(a, $urandom, s);
    end
  endtask

  task automatic shuffle_nodes(input int cnt);
    int          j;
    addr_t       ta;
    logic [31:0] tv;
    link_t       ts;
    for (int i = cnt - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      ta = ld_addr[i]; ld_addr[i] = ld_addr[j]; ld_addr[j] = ta;
      tv = ld_val[i];  ld_val[i]  = ld_val[j];  ld_val[j]  = tv;
      ts = ld_succ[i]; ld_succ[i] = ld_succ[j]; ld_succ[j] = ts;
    end
  endtask

  // one node word; valid stays up across back-to-back words
  task automatic send_word(input addr_t a, input logic [31:0] v, input link_t s,
                           input logic done);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    node_address_i      <= a;
    node_value_i        <= v;
    successor_address_i <= s;
    load_done_i         <= done;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
  endtask

  task automatic send_load();
    for (int i = 0; i < ld_addr.size(); i++)
      send_word(ld_addr[i], ld_val[i], ld_succ[i], i == ld_addr.size() - 1);
    ld_addr.delete();
    ld_val.delete();
    ld_succ.delete();
  endtask

  // wait until every predicted word is out and the walk has surely finished
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (words_due != 0);
    repeat (QuietCycles) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [CfgDataW-1:0] start_v,
                          input logic [CfgDataW-1:0] group_v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_START_ADDR;
    cfg_data_i  <= start_v;
    @(posedge clk_i);
    cfg_index_i <= CFG_GROUP_SIZE;
    cfg_data_i  <= group_v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    start_cur = start_v[StartW-1:0];
  endtask

  initial begin : stim
    int                  base;
    int                  ld_idx;
    int                  n;
    int                  kind;
    int                  r;
    int                  g;
    bit                  reconfig;
    addr_t               head;
    logic [CfgDataW-1:0] start_v;
    logic [CfgDataW-1:0] group_v;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = CFG_START_ADDR;
    cfg_data_i          = '0;
    in_valid_i          = 1'b0;
    node_address_i      = '0;
    node_value_i        = '0;
    successor_address_i = '0;
    load_done_i         = 1'b0;
    idle_en             = 1'b1;
    hold_asks           = 0;
    sent_cnt            = 0;
    start_cur           = StartReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset start register is -1: empty chain
    add_node('0, '0, '1);
    send_load();

    // group size zero, address and value extremes
    drain();
    set_regs(CfgDataW'(131071), CfgDataW'(0));
    add_node(addr_t'(0), 32'h8000_0000, '1);
    add_node(addr_t'(131071), 32'h7fff_ffff, link_t'(77));
    add_node(addr_t'(77), 32'hffff_ffff, link_t'(0));
    send_load();

    // pairs reversed, odd tail kept; later duplicate ignored, stray node
    // unreachable, chain ends on a negative successor other than -1
    drain();
    set_regs(CfgDataW'(10), CfgDataW'(2));
    add_node(addr_t'(10), 32'd1, link_t'(11));
    add_node(addr_t'(11), 32'd2, link_t'(12));
    add_node(addr_t'(12), 32'd3, link_t'(13));
    add_node(addr_t'(11), 32'd99, link_t'(10));
    add_node(addr_t'(99), 32'd7, link_t'(10));
    add_node(addr_t'(13), 32'd4, link_t'(14));
    add_node(addr_t'(14), 32'd5, link_t'(18'h2000a));
    send_load();

    // group larger than the chain; the chain loops back on itself
    drain();
    set_regs(CfgDataW'(3), CfgDataW'(64));
    add_node(addr_t'(3), 32'haaaa_aaaa, link_t'(4));
    add_node(addr_t'(4), 32'h5555_5555, link_t'(3));
    send_load();

    // start address never loaded
    drain();
    set_regs(CfgDataW'(500), CfgDataW'(1));
    add_node(addr_t'(1), 32'h5555_5555, '1);
    send_load();

    // successor not loaded ends the walk; whole chain is one group
    drain();
    set_regs(CfgDataW'(20), CfgDataW'(3));
    add_node(addr_t'(20), 32'd20, link_t'(21));
    add_node(addr_t'(21), 32'd21, link_t'(22));
    add_node(addr_t'(22), 32'd22, link_t'(999));
    send_load();

    // random loads: mostly well-formed chains, some noise
    base   = sent_cnt;
    ld_idx = 0;
    while (sent_cnt - base < ItemTarget) begin
      if (sent_cnt - base > ItemTarget - 50) idle_en <= 1'b0;
      kind = (ld_idx == 2 || ld_idx == 4 || ld_idx == 5) ? 0 : $urandom_range(0, 9);
      n    = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
      if (ld_idx == 2) n = 64;
      if (ld_idx == 4 || ld_idx == 5) n = $urandom_range(4, 8);
      // load 5 follows load 4 with no pause, into the held-off output
      reconfig = (ld_idx != 5) && (ld_idx < 5 || $urandom_range(0, 9) < 7);
      if (kind <= 6) begin
        build_chain(n, !reconfig && !start_cur[StartW-1]);
        head = ld_addr[0];
        if (ld_idx == 2) begin
          // full table, then two words that are dropped
          shuffle_nodes(n);
          add_extras(2);
        end else begin
          if ($urandom_range(0, 9) < 3) add_extras($urandom_range(1, 3));
          shuffle_nodes(ld_addr.size());
        end
      end else begin
        build_noise(n, kind == 9);
      end
      if (reconfig) begin
        r = $urandom_range(0, 19);
        if (kind > 6) start_v = (r < 3) ? '1 : CfgDataW'($urandom_range(0, 15));
        else if (r == 0) start_v = '1;
        else if (r == 1) start_v = {1'b1, addr_t'($urandom)};
        else if (r == 2) start_v = {1'b0, fresh_addr()};
        else start_v = {1'b0, head};
        if (ld_idx == 2 || ld_idx == 4) start_v = {1'b0, head};
        r = $urandom_range(0, 9);
        if (r == 0) g = 0;
        else if (r == 1) g = 64;
        else if (r == 2) g = $urandom_range(0, 64);
        else g = $urandom_range(1, 8);
        if (ld_idx == 2) g = 64;
        group_v = CfgDataW'(g);
        if ($urandom_range(0, 1))
          group_v[CfgDataW-1:GroupW] = (CfgDataW - GroupW)'($urandom);
        drain();
        set_regs(start_v, group_v);
      end
      if (ld_idx == 4) hold_asks <= hold_asks + 1;
      send_load();
      ld_idx++;
    end

    drain();
    if (err_total == 0 && words_due == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

[linked_list_group_reverser.f]
hdl/llgr_pkg.sv
hdl/llgr_ram.sv
hdl/linked_list_group_reverser.sv
tb/sv/reverser_check.sv
tb/sv/tb.sv
